// ----- rtl/cfa_pkg.sv -----
// ----------------------------------------------------------------------------
// cfa_pkg
// Shared opcodes, status codes and classification types for the complex
// fixed-point arithmetic unit.
// ----------------------------------------------------------------------------
package cfa_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 12;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_SUB  = 4'd1;
  localparam logic [3:0] OP_MUL  = 4'd2;
  localparam logic [3:0] OP_DIV  = 4'd3;
  localparam logic [3:0] OP_ADDK = 4'd4;
  localparam logic [3:0] OP_SUBK = 4'd5;
  localparam logic [3:0] OP_MULK = 4'd6;
  localparam logic [3:0] OP_DIVK = 4'd7;
  localparam logic [3:0] OP_CONJ = 4'd8;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  typedef enum logic [2:0] {
    K_LIN,
    K_MUL,
    K_MULK,
    K_DIV,
    K_ZDIV,
    K_NOP
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  div_k;
  } class_t;

  localparam int CLASS_W = $bits(class_t);

endpackage

// ----- rtl/cfa_front.sv -----
// ----------------------------------------------------------------------------
// cfa_front
// Accepts commands, classifies the opcode and packs the transaction for the
// queue.
// ----------------------------------------------------------------------------
module cfa_front #(
  parameter int DATA_WIDTH = 16,
  parameter int ITEM_W     = cfa_pkg::CLASS_W + 4 + 5 * 16
) (
  input  logic                         start,
  output logic                         busy,
  input  logic [3:0]                   in_opcode,
  input  logic signed [DATA_WIDTH-1:0] in_a_re,
  input  logic signed [DATA_WIDTH-1:0] in_a_im,
  input  logic signed [DATA_WIDTH-1:0] in_b_re,
  input  logic signed [DATA_WIDTH-1:0] in_b_im,
  input  logic signed [DATA_WIDTH-1:0] in_scalar_k,
  input  logic                         q_full,
  output logic                         q_push,
  output logic [ITEM_W-1:0]            q_item
);
  import cfa_pkg::*;

  class_t cls;

  always_comb begin
    cls.kind  = K_NOP;
    cls.div_k = 1'b0;
    case (in_opcode)
      OP_ADD, OP_SUB, OP_ADDK, OP_SUBK, OP_CONJ: cls.kind = K_LIN;
      OP_MUL:  cls.kind = K_MUL;
      OP_MULK: cls.kind = K_MULK;
      OP_DIV: begin
        cls.kind = (in_b_re == '0 && in_b_im == '0) ? K_ZDIV : K_DIV;
      end
      OP_DIVK: begin
        cls.div_k = 1'b1;
        cls.kind  = (in_scalar_k == '0) ? K_ZDIV : K_DIV;
      end
      default: cls.kind = K_NOP;
    endcase
  end

  assign busy   = q_full;
  assign q_push = start && !q_full;
  assign q_item = {cls, in_opcode, in_a_re, in_a_im, in_b_re, in_b_im, in_scalar_k};

endmodule

// ----- rtl/cfa_queue.sv -----
// ----------------------------------------------------------------------------
// cfa_queue
// Small first-in first-out queue between the front and the execution back end.
// ----------------------------------------------------------------------------
module cfa_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] head
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign valid   = (count_r != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign head    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/cfa_back.sv -----
// ----------------------------------------------------------------------------
// cfa_back
// Execution back end: a product stage, then either a rounding and saturation
// stage or a bit-serial divider that works on both result parts at once.
// ----------------------------------------------------------------------------
module cfa_back #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 12,
  parameter int ITEM_W     = cfa_pkg::CLASS_W + 4 + 5 * 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  logic [ITEM_W-1:0]            q_item,
  output logic                         q_pop,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] out_res_re,
  output logic signed [DATA_WIDTH-1:0] out_res_im,
  output logic [1:0]                   out_status
);
  import cfa_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * DW;           // product width
  localparam int LW = DW + F + 2;       // linear result width
  localparam int SW = 2 * DW + F + 2;   // common wide width
  localparam int NW = 2 * DW + F + 1;   // dividend width, one quotient bit each
  localparam int QW = DW + 1;           // kept quotient bits
  localparam int CW = $clog2(NW);
  localparam logic [SW-1:0] LIM_POS = (SW'(1) << (DW - 1)) - SW'(1);
  localparam logic [SW-1:0] LIM_NEG = SW'(1) << (DW - 1);
  localparam logic [SW-1:0] HALF    = SW'(1) << (F - 1);

  // Unpack the queue head.
  class_t              h_cls;
  logic [3:0]          h_op;
  logic signed [DW-1:0] h_are, h_aim, h_bre, h_bim, h_k;

  assign {h_cls, h_op, h_are, h_aim, h_bre, h_bim, h_k} = q_item;

  // Product stage registers.
  logic                s1_valid_r;
  class_t              s1_cls_r;
  logic signed [DW-1:0] s1_are_r, s1_aim_r, s1_k_r;
  logic signed [LW-1:0] s1_lre_r, s1_lim_r;
  logic signed [PW-1:0] p_rr_r, p_ii_r, p_ir_r, p_ri_r, p_bb_r, p_qq_r;
  logic signed [PW-1:0] pk_re_r, pk_im_r;

  logic signed [LW-1:0] lre, lim, ksh;
  logic                s1_take, s2_take;

  // Divider registers.
  logic                dv_busy_r;
  logic [CW-1:0]       dv_cnt_r;
  logic [PW-1:0]       dv_den_r;
  logic [NW-1:0]       dv_nre_r, dv_nim_r;
  logic [PW-1:0]       rem_re_r, rem_im_r;
  logic [QW-1:0]       q_re_r, q_im_r;
  logic                ovf_re_r, ovf_im_r, sgn_re_r, sgn_im_r;

  // Output registers.
  logic                out_valid_r;
  logic signed [DW-1:0] res_re_r, res_im_r;
  logic [1:0]          status_r;

  function automatic logic [DW:0] fin(input logic neg, input logic [SW-1:0] mag);
    logic [SW-1:0] lim;
    logic [SW-1:0] m;
    logic          sat;
    lim = neg ? LIM_NEG : LIM_POS;
    m   = mag;
    sat = 1'b0;
    if (mag > lim) begin
      m   = lim;
      sat = 1'b1;
    end
    return {sat, (neg ? -m[DW-1:0] : m[DW-1:0])};
  endfunction

  function automatic logic [PW:0] dstep(input logic [PW-1:0] rem, input logic bit_in,
                                        input logic [PW-1:0] den);
    logic [PW:0] trial;
    logic        ge;
    logic [PW:0] diff;
    trial = {rem, bit_in};
    ge    = (trial >= {1'b0, den});
    diff  = trial - {1'b0, den};
    return {ge, (ge ? diff[PW-1:0] : trial[PW-1:0])};
  endfunction

  // Linear operations of the product stage.
  always_comb begin
    ksh = LW'(h_k) <<< F;
    lre = '0;
    lim = '0;
    case (h_op)
      OP_ADD: begin
        lre = LW'(h_are) + LW'(h_bre);
        lim = LW'(h_aim) + LW'(h_bim);
      end
      OP_SUB: begin
        lre = LW'(h_are) - LW'(h_bre);
        lim = LW'(h_aim) - LW'(h_bim);
      end
      OP_ADDK: begin
        lre = LW'(h_are) + ksh;
        lim = LW'(h_aim);
      end
      OP_SUBK: begin
        lre = LW'(h_are) - ksh;
        lim = LW'(h_aim);
      end
      OP_CONJ: begin
        lre = LW'(h_bre);
        lim = -LW'(h_bim);
      end
      default: begin
        lre = '0;
        lim = '0;
      end
    endcase
  end

  assign s2_take = s1_valid_r && !dv_busy_r;
  assign s1_take = !s1_valid_r || s2_take;
  assign q_pop   = q_valid && s1_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_take) begin
      s1_valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_cls_r <= h_cls;
      s1_are_r <= h_are;
      s1_aim_r <= h_aim;
      s1_k_r   <= h_k;
      s1_lre_r <= lre;
      s1_lim_r <= lim;
      p_rr_r   <= h_are * h_bre;
      p_ii_r   <= h_aim * h_bim;
      p_ir_r   <= h_aim * h_bre;
      p_ri_r   <= h_are * h_bim;
      p_bb_r   <= h_bre * h_bre;
      p_qq_r   <= h_bim * h_bim;
      pk_re_r  <= h_are * h_k;
      pk_im_r  <= h_aim * h_k;
    end
  end

  // Direct results: sums, exact scalar products and rounded complex products.
  logic signed [SW-1:0] v_re, v_im;
  logic                rnd;
  logic                neg_re, neg_im;
  logic [SW-1:0]       m_re, m_im;
  logic [DW:0]         f_re, f_im;

  always_comb begin
    v_re = '0;
    v_im = '0;
    rnd  = 1'b0;
    case (s1_cls_r.kind)
      K_LIN: begin
        v_re = SW'(s1_lre_r);
        v_im = SW'(s1_lim_r);
      end
      K_MULK: begin
        v_re = SW'(pk_re_r);
        v_im = SW'(pk_im_r);
      end
      K_MUL: begin
        v_re = SW'(p_rr_r) - SW'(p_ii_r);
        v_im = SW'(p_ir_r) + SW'(p_ri_r);
        rnd  = 1'b1;
      end
      default: begin
        v_re = '0;
        v_im = '0;
      end
    endcase
    neg_re = v_re[SW-1];
    neg_im = v_im[SW-1];
    m_re   = neg_re ? -v_re : v_re;
    m_im   = neg_im ? -v_im : v_im;
    if (rnd) begin
      m_re = (m_re + HALF) >> F;
      m_im = (m_im + HALF) >> F;
    end
    f_re = fin(neg_re, m_re);
    f_im = fin(neg_im, m_im);
  end

  // Divider load values.
  logic signed [PW:0]   ld_nre, ld_nim;
  logic                ld_sre, ld_sim;
  logic [PW:0]         ld_mre, ld_mim;
  logic [PW-1:0]       ld_den;
  logic [NW-1:0]       ld_dre, ld_dim;

  always_comb begin
    if (s1_cls_r.div_k) begin
      ld_nre = (PW+1)'(s1_are_r);
      ld_nim = (PW+1)'(s1_aim_r);
      ld_den = s1_k_r[DW-1] ? PW'(-(PW+1)'(s1_k_r)) : PW'(s1_k_r);
    end else begin
      ld_nre = (PW+1)'(p_rr_r) + (PW+1)'(p_ii_r);
      ld_nim = (PW+1)'(p_ir_r) - (PW+1)'(p_ri_r);
      ld_den = PW'(p_bb_r) + PW'(p_qq_r);
    end
    ld_mre = ld_nre[PW] ? -ld_nre : ld_nre;
    ld_mim = ld_nim[PW] ? -ld_nim : ld_nim;
    if (s1_cls_r.div_k) begin
      ld_sre = ld_nre[PW] ^ s1_k_r[DW-1];
      ld_sim = ld_nim[PW] ^ s1_k_r[DW-1];
      ld_dre = NW'(ld_mre) << 1;
      ld_dim = NW'(ld_mim) << 1;
    end else begin
      ld_sre = ld_nre[PW];
      ld_sim = ld_nim[PW];
      ld_dre = NW'(ld_mre) << (F + 1);
      ld_dim = NW'(ld_mim) << (F + 1);
    end
  end

  // One quotient bit per cycle for each part.
  logic [PW:0]   st_re, st_im;
  logic [QW-1:0] q_re_nxt, q_im_nxt;
  logic          ovf_re_nxt, ovf_im_nxt;
  logic [QW:0]   rq_re, rq_im;
  logic [DW:0]   d_re, d_im;
  logic          dv_last, dv_load;

  always_comb begin
    st_re      = dstep(rem_re_r, dv_nre_r[NW-1], dv_den_r);
    st_im      = dstep(rem_im_r, dv_nim_r[NW-1], dv_den_r);
    q_re_nxt   = {q_re_r[QW-2:0], st_re[PW]};
    q_im_nxt   = {q_im_r[QW-2:0], st_im[PW]};
    ovf_re_nxt = ovf_re_r | q_re_r[QW-1];
    ovf_im_nxt = ovf_im_r | q_im_r[QW-1];
    // The extra quotient bit carries the rounding half.
    rq_re      = ({1'b0, q_re_nxt} + (QW+1)'(1)) >> 1;
    rq_im      = ({1'b0, q_im_nxt} + (QW+1)'(1)) >> 1;
    d_re       = fin(sgn_re_r, SW'({ovf_re_nxt, rq_re}));
    d_im       = fin(sgn_im_r, SW'({ovf_im_nxt, rq_im}));
  end

  assign dv_last = dv_busy_r && (dv_cnt_r == CW'(NW - 1));
  assign dv_load = s2_take && (s1_cls_r.kind == K_DIV);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_busy_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (dv_load) begin
        dv_busy_r <= 1'b1;
      end else if (dv_last) begin
        dv_busy_r <= 1'b0;
      end
      out_valid_r <= dv_last || (s2_take && s1_cls_r.kind != K_DIV);
    end
  end

  always_ff @(posedge clk) begin
    if (dv_load) begin
      dv_cnt_r <= '0;
      dv_den_r <= ld_den;
      dv_nre_r <= ld_dre;
      dv_nim_r <= ld_dim;
      rem_re_r <= '0;
      rem_im_r <= '0;
      q_re_r   <= '0;
      q_im_r   <= '0;
      ovf_re_r <= 1'b0;
      ovf_im_r <= 1'b0;
      sgn_re_r <= ld_sre;
      sgn_im_r <= ld_sim;
    end else if (dv_busy_r) begin
      dv_cnt_r <= dv_cnt_r + 1'b1;
      dv_nre_r <= dv_nre_r << 1;
      dv_nim_r <= dv_nim_r << 1;
      rem_re_r <= st_re[PW-1:0];
      rem_im_r <= st_im[PW-1:0];
      q_re_r   <= q_re_nxt;
      q_im_r   <= q_im_nxt;
      ovf_re_r <= ovf_re_nxt;
      ovf_im_r <= ovf_im_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (dv_last) begin
      res_re_r <= d_re[DW-1:0];
      res_im_r <= d_im[DW-1:0];
      status_r <= (d_re[DW] || d_im[DW]) ? ST_SAT : ST_OK;
    end else if (s2_take && s1_cls_r.kind == K_ZDIV) begin
      res_re_r <= '0;
      res_im_r <= '0;
      status_r <= ST_DIV0;
    end else if (s2_take) begin
      res_re_r <= f_re[DW-1:0];
      res_im_r <= f_im[DW-1:0];
      status_r <= (f_re[DW] || f_im[DW]) ? ST_SAT : ST_OK;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_res_re = res_re_r;
  assign out_res_im = res_im_r;
  assign out_status = status_r;

endmodule

// ----- rtl/complex_fixed_point_alu.sv -----
// ----------------------------------------------------------------------------
// complex_fixed_point_alu
// Complex arithmetic unit on signed fixed-point operands: add, subtract,
// multiply, divide, scalar forms and conjugate, with saturation status.
//
//   Channel   Ports                               Transfer
//   command   start, busy, in_*                   start && !busy
//   result    out_valid, out_res_*, out_status    out_valid, one cycle
//
// Non-divide operations run at one transaction per cycle while no divide is in
// progress; each passes the queue, the product stage and the output registers.
// A divide holds the back end until the one-bit-per-cycle divider is through;
// the queue keeps accepting until it is full, then busy rises.
// Reset is synchronous and empties the queue and the pipeline.
// The receiver cannot stall; results appear in command order.
// ----------------------------------------------------------------------------
module complex_fixed_point_alu #(
  parameter int DATA_WIDTH = cfa_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cfa_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [3:0]                   in_opcode,
  input  logic signed [DATA_WIDTH-1:0] in_a_re,
  input  logic signed [DATA_WIDTH-1:0] in_a_im,
  input  logic signed [DATA_WIDTH-1:0] in_b_re,
  input  logic signed [DATA_WIDTH-1:0] in_b_im,
  input  logic signed [DATA_WIDTH-1:0] in_scalar_k,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] out_res_re,
  output logic signed [DATA_WIDTH-1:0] out_res_im,
  output logic [1:0]                   out_status
);
  import cfa_pkg::*;

  localparam int ITEM_W = CLASS_W + 4 + 5 * DATA_WIDTH;

  logic              q_full, q_push, q_pop, q_valid;
  logic [ITEM_W-1:0] q_in, q_head;

  cfa_front #(
    .DATA_WIDTH (DATA_WIDTH),
    .ITEM_W     (ITEM_W)
  ) u_front (
    .start       (start),
    .busy        (busy),
    .in_opcode   (in_opcode),
    .in_a_re     (in_a_re),
    .in_a_im     (in_a_im),
    .in_b_re     (in_b_re),
    .in_b_im     (in_b_im),
    .in_scalar_k (in_scalar_k),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_item      (q_in)
  );

  cfa_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  cfa_back #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .ITEM_W     (ITEM_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_res_re (out_res_re),
    .out_res_im (out_res_im),
    .out_status (out_status)
  );

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the complex fixed-point arithmetic unit. A directed
// table covers extremes, every opcode, divide by zero, saturation and unused
// opcodes; weighted random commands follow. A behavioral predictor computes
// results not given in the table; results are compared in command order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cfa_pkg::*;

  localparam int DW = 16;
  localparam int FB = 12;
  localparam int N_RANDOM = 1250;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic [3:0]     op;
    logic [DW-1:0]  a_re, a_im, b_re, b_im, k;
  } cmd_t;

  typedef struct {
    logic [DW-1:0] re, im;
    logic [1:0]    st;
  } res_t;

  typedef struct {
    cmd_t c;
    bit   typed;
    res_t r;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [3:0] in_opcode = '0;
  logic signed [DW-1:0] in_a_re = '0, in_a_im = '0, in_b_re = '0, in_b_im = '0;
  logic signed [DW-1:0] in_scalar_k = '0;
  logic out_valid;
  logic signed [DW-1:0] out_res_re, out_res_im;
  logic [1:0] out_status;

  res_t expected_q[$];
  int errors = 0;
  longint cycles = 0;
  row_t rows[$];

  complex_fixed_point_alu u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_a_re(in_a_re), .in_a_im(in_a_im),
    .in_b_re(in_b_re), .in_b_im(in_b_im), .in_scalar_k(in_scalar_k),
    .out_valid(out_valid), .out_res_re(out_res_re), .out_res_im(out_res_im),
    .out_status(out_status)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[complex_fixed_point_alu] ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    errors++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  // Clamp a signed magnitude to the DW range and flag saturation.
  function automatic logic [DW-1:0] clamp(input bit neg, input logic [127:0] mag,
                                          inout bit sat);
    logic [127:0] lim;
    lim = neg ? (128'd1 << (DW-1)) : (128'd1 << (DW-1)) - 1;
    if (mag > lim) begin
      mag = lim;
      sat = 1'b1;
    end
    clamp = neg ? DW'(-mag) : DW'(mag);
  endfunction

  // Rounded quotient n*2^sh/d with ties away from zero, on magnitudes.
  function automatic logic [127:0] round_quot(input logic [127:0] n,
                                              input logic [127:0] d, input int sh);
    logic [127:0] num;
    num = n << (sh + 1);
    round_quot = ((num / d) + 1) >> 1;
  endfunction

  function automatic logic [127:0] mag(input longint x);
    mag = (x < 0) ? 128'(-x) : 128'(x);
  endfunction

  function automatic res_t predict_alu(input cmd_t c);
    res_t r;
    longint ar, ai, br, bi, k, xr, xi, den;
    bit sat, nr, ni, zdiv;
    logic [127:0] mr, mi;
    ar = longint'(signed'(c.a_re)); ai = longint'(signed'(c.a_im));
    br = longint'(signed'(c.b_re)); bi = longint'(signed'(c.b_im));
    k = longint'(signed'(c.k));
    sat = 0; zdiv = 0; xr = 0; xi = 0;
    nr = 0; ni = 0; mr = 0; mi = 0;
    case (c.op)
      OP_ADD:  begin xr = ar + br; xi = ai + bi; end
      OP_SUB:  begin xr = ar - br; xi = ai - bi; end
      OP_ADDK: begin xr = ar + (k <<< FB); xi = ai; end
      OP_SUBK: begin xr = ar - (k <<< FB); xi = ai; end
      OP_MULK: begin xr = ar * k; xi = ai * k; end
      OP_CONJ: begin xr = br; xi = -bi; end
      default: ;
    endcase
    nr = xr < 0; ni = xi < 0; mr = mag(xr); mi = mag(xi);
    if (c.op == OP_MUL) begin
      xr = ar * br - ai * bi; xi = ai * br + ar * bi;
      nr = xr < 0; ni = xi < 0;
      mr = (mag(xr) + (128'd1 << (FB-1))) >> FB;
      mi = (mag(xi) + (128'd1 << (FB-1))) >> FB;
    end else if (c.op == OP_DIV) begin
      den = br * br + bi * bi;
      if (den == 0) zdiv = 1;
      else begin
        xr = ar * br + ai * bi; xi = ai * br - ar * bi;
        nr = xr < 0; ni = xi < 0;
        mr = round_quot(mag(xr), 128'(den), FB);
        mi = round_quot(mag(xi), 128'(den), FB);
      end
    end else if (c.op == OP_DIVK) begin
      if (k == 0) zdiv = 1;
      else begin
        nr = (ar < 0) != (k < 0); ni = (ai < 0) != (k < 0);
        mr = round_quot(mag(ar), mag(k), 0);
        mi = round_quot(mag(ai), mag(k), 0);
      end
    end
    if (zdiv) begin
      r.re = '0; r.im = '0; r.st = ST_DIV0;
    end else begin
      r.re = clamp(nr, mr, sat);
      r.im = clamp(ni, mi, sat);
      r.st = sat ? ST_SAT : ST_OK;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) report_mismatch("result with none expected");
      else begin
        e = expected_q.pop_front();
        if (out_res_re !== e.re)
          report_mismatch($sformatf("res_re %h expected %h", out_res_re, e.re));
        if (out_res_im !== e.im)
          report_mismatch($sformatf("res_im %h expected %h", out_res_im, e.im));
        if (out_status !== e.st)
          report_mismatch($sformatf("status %0d expected %0d", out_status, e.st));
      end
    end
  end

  function automatic logic [DW-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return '0;
      3: return DW'($urandom_range(0, 8191)) - 16'd4096;
      4: return 16'h1000;
      default: return DW'($urandom);
    endcase
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    c.op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                        : 4'($urandom_range(0, 8));
    c.a_re = pick_value(); c.a_im = pick_value();
    c.b_re = pick_value(); c.b_im = pick_value();
    case ($urandom_range(0, 3))
      0: c.k = '0;
      1: c.k = DW'($urandom_range(0, 31)) - 16'd16;
      default: c.k = pick_value();
    endcase
    if (c.op == OP_DIV && $urandom_range(0, 9) == 0) begin
      c.b_re = '0; c.b_im = '0;
    end
    return c;
  endfunction

  // Issue one command; the caller decides about idle gaps.
  task automatic issue(input cmd_t c, input bit typed, input res_t r);
    start <= 1'b1;
    in_opcode <= c.op; in_a_re <= c.a_re; in_a_im <= c.a_im;
    in_b_re <= c.b_re; in_b_im <= c.b_im; in_scalar_k <= c.k;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(typed ? r : predict_alu(c));
  endtask

  function automatic row_t mk(input logic [3:0] op, input logic [DW-1:0] ar, ai, br,
                              bi, k, input bit typed = 0, input logic [DW-1:0] rr = 0,
                              input logic [DW-1:0] ri = 0, input logic [1:0] st = 0);
    row_t w;
    w.c = '{op, ar, ai, br, bi, k};
    w.typed = typed;
    w.r = '{rr, ri, st};
    return w;
  endfunction

  initial begin
    res_t dummy;
    int gap;
    dummy = '{0, 0, 0};
    rows.push_back(mk(OP_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 0,
                      1, 16'h7fff, 16'h8000, ST_SAT));
    rows.push_back(mk(OP_ADD, 16'h1000, 16'h0001, 16'h2000, 16'hffff, 0,
                      1, 16'h3000, 16'h0000, ST_OK));
    rows.push_back(mk(OP_SUB, 16'h8000, 16'h7fff, 16'h0001, 16'hffff, 0,
                      1, 16'h8000, 16'h7fff, ST_SAT));
    rows.push_back(mk(OP_MUL, 16'h1000, 16'h1000, 16'h1000, 16'h1000, 0));
    rows.push_back(mk(OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0));
    rows.push_back(mk(OP_MUL, 16'h0001, 16'h0000, 16'h0800, 16'h0000, 0));
    rows.push_back(mk(OP_MUL, 16'hffff, 16'h0000, 16'h0800, 16'h0000, 0));
    rows.push_back(mk(OP_DIV, 16'h1234, 16'h4321, 16'h0000, 16'h0000, 5,
                      1, 16'h0000, 16'h0000, ST_DIV0));
    rows.push_back(mk(OP_DIV, 16'h7fff, 16'h8000, 16'h0001, 16'h0000, 0));
    rows.push_back(mk(OP_DIV, 16'h1000, 16'h2000, 16'h8000, 16'h7fff, 0));
    rows.push_back(mk(OP_DIV, 16'h0001, 16'h0000, 16'h0003, 16'h0000, 0));
    rows.push_back(mk(OP_ADDK, 16'h0000, 16'h1234, 0, 0, 16'h0007,
                      1, 16'h7000, 16'h1234, ST_OK));
    rows.push_back(mk(OP_ADDK, 16'h7fff, 16'h0000, 0, 0, 16'h7fff));
    rows.push_back(mk(OP_SUBK, 16'h8000, 16'h0000, 0, 0, 16'h8000));
    rows.push_back(mk(OP_SUBK, 16'h0000, 16'h8000, 0, 0, 16'h0001));
    rows.push_back(mk(OP_MULK, 16'h8000, 16'h0100, 0, 0, 16'hffff,
                      1, 16'h7fff, 16'hff00, ST_SAT));
    rows.push_back(mk(OP_MULK, 16'h7fff, 16'h8000, 0, 0, 16'h8000));
    rows.push_back(mk(OP_DIVK, 16'h1234, 16'h5678, 0, 0, 16'h0000,
                      1, 16'h0000, 16'h0000, ST_DIV0));
    rows.push_back(mk(OP_DIVK, 16'h8000, 16'h0005, 0, 0, 16'hffff));
    rows.push_back(mk(OP_DIVK, 16'h0005, 16'hfffb, 0, 0, 16'h0002));
    rows.push_back(mk(OP_DIVK, 16'h7fff, 16'h8000, 0, 0, 16'h8000));
    rows.push_back(mk(OP_CONJ, 0, 0, 16'h7fff, 16'h8000, 0,
                      1, 16'h7fff, 16'h7fff, ST_SAT));
    rows.push_back(mk(OP_CONJ, 0, 0, 16'h8000, 16'h7fff, 0,
                      1, 16'h8000, 16'h8001, ST_OK));
    rows.push_back(mk(4'd15, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                      1, 16'h0000, 16'h0000, ST_OK));
    rows.push_back(mk(4'd9, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                      1, 16'h0000, 16'h0000, ST_OK));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) issue(rows[i].c, rows[i].typed, rows[i].r);
    for (int n = 0; n < N_RANDOM; n++) begin
      issue(random_cmd(), 0, dummy);
      // Idle bursts in the first part of the run only.
      if (n < N_RANDOM - 150 && $urandom_range(0, 5) == 0) begin
        start <= 1'b0;
        gap = $urandom_range(1, 16);
        repeat (gap) @(posedge clk);
      end
    end
    start <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("[complex_fixed_point_alu] OK");
    end else begin
      $display("[complex_fixed_point_alu] ERROR");
    end
    $finish;
  end
endmodule
